[hw/rtl/hash_table_linear_probe_macros.svh]
// Assertion macros used by the hash table RTL.
`ifndef HASH_TABLE_LINEAR_PROBE_MACROS_SVH
`define HASH_TABLE_LINEAR_PROBE_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define HTLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define HTLP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/htlp_pkg.sv]
// Types and codes of the linear probing hash table.
package htlp_pkg;

  localparam int TABLE_SIZE_DEF = 32;

  localparam int CMD_W     = 2;
  localparam int KEY_W     = 31;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int SLOT_IDX_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] value_out;
    logic [SLOT_IDX_W-1:0]   slot_index;
  } out_word_t;

endpackage

[hw/rtl/hash_table_linear_probe.sv]
// Open addressing hash table with linear probing, one command word in, one result word out.
//
// Each input word is an insert, search or delete on a 31-bit key. The home slot is the key
// modulo TABLE_SIZE, computed in order: a multiplication by the reciprocal of the size
// gives an estimate of the quotient, a multiply-back and subtract gives a remainder below
// twice the size, and one compare and subtract brings that remainder into range. Probing
// then visits one slot at a time, first reading the slot memories and then deciding,
// wrapping at the end of the table and giving up after TABLE_SIZE slots with
// "table full" (insert) or "not found" (search, delete). The result is then handed
// to the output register; an unknown command answers "not found" without probing.
// A finished result waits until the receiver no longer holds the output register.
// Insert does not look for duplicates; search and delete act on the first matching key
// along the probe path and pass over tombstones, and delete leaves a tombstone. After
// reset the block runs a clearing pass that marks every slot empty, one slot per cycle,
// and stalls the input meanwhile. A finished result waits in the output register, and
// the next word is accepted while it waits. Keys and values of slots never written are
// not cleared, and their contents are never used.
`include "hash_table_linear_probe_macros.svh"

module hash_table_linear_probe #(
  parameter int TABLE_SIZE = htlp_pkg::TABLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  htlp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output htlp_pkg::out_word_t out_data
);

  import htlp_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
  localparam logic [IDX_W:0]   SIZE_C   = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [KEY_W-1:0] SIZE_K   = KEY_W'(TABLE_SIZE);
  // Reciprocal of the table size scaled by 2^32, rounded down.
  localparam logic [31:0]      RECIP_K  = 32'((64'd1 << 32) / TABLE_SIZE);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_REM   = 3'd3;
  localparam logic [2:0] S_FIX   = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_EVAL  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // Slot memories. The status memory is swept to empty after reset.
  logic [1:0]       status_mem [TABLE_SIZE];
  logic [KEY_W-1:0] key_mem    [TABLE_SIZE];
  logic [VAL_W-1:0] value_mem  [TABLE_SIZE];

  // Control state.
  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;       // clear address, then probe slot
  logic [IDX_W-1:0] cnt_r, cnt_nxt;       // slots probed so far
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [KEY_W-1:0] quo_r, quo_nxt;       // quotient estimate, low by at most one
  logic [IDX_W:0]   rem_r, rem_nxt;       // remainder below twice the table size
  out_word_t        res_r, res_nxt;
  out_word_t        out_data_r, out_data_nxt;

  // Registered memory read data.
  logic [1:0]       rd_status_r;
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_value_r;

  // Memory write port.
  logic             st_wr_en;
  logic [1:0]       st_wr_data;
  logic             kv_wr_en;

  // Home slot steps and probe helpers.
  logic [KEY_W-1:0] quo_est;
  logic [IDX_W:0]   rem_est;
  logic [IDX_W-1:0] rem_fix;
  logic [IDX_W-1:0] pos_wrap;
  logic             in_accept;
  logic             out_free;
  logic             key_hit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The scaled reciprocal is rounded down, so the quotient estimate is never too high and
  // falls short by at most one. The remainder it leaves is then below twice the size.
  assign quo_est = KEY_W'(({32'b0, key_r} * {31'b0, RECIP_K}) >> 32);
  assign rem_est = (IDX_W + 1)'(key_r - KEY_W'(quo_r * SIZE_K));
  assign rem_fix = (rem_r >= SIZE_C) ? IDX_W'(rem_r - SIZE_C) : IDX_W'(rem_r);

  assign pos_wrap = (pos_r == LAST_IDX) ? '0 : pos_r + IDX_W'(1);
  assign key_hit  = (rd_status_r == SLOT_USED) && (rd_key_r == key_r);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    st_wr_en      = 1'b0;
    st_wr_data    = SLOT_EMPTY;
    kv_wr_en      = 1'b0;

    case (state_r)
      S_CLEAR: begin
        st_wr_en   = 1'b1;
        st_wr_data = SLOT_EMPTY;
        if (pos_r == LAST_IDX) begin
          pos_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt = pos_r + IDX_W'(1);
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt = in_data.cmd;
          key_nxt = in_data.key;
          val_nxt = in_data.value_in;
          pos_nxt = '0;
          cnt_nxt = '0;
          if (in_data.cmd == CMD_INSERT || in_data.cmd == CMD_SEARCH ||
              in_data.cmd == CMD_DELETE) begin
            state_nxt = S_MOD;
          end else begin
            res_nxt.status     = ST_NOT_FOUND;
            res_nxt.value_out  = '0;
            res_nxt.slot_index = '0;
            state_nxt          = S_DONE;
          end
        end
      end

      S_MOD: begin
        quo_nxt   = quo_est;
        state_nxt = S_REM;
      end

      S_REM: begin
        rem_nxt   = rem_est;
        state_nxt = S_FIX;
      end

      S_FIX: begin
        pos_nxt   = rem_fix;
        state_nxt = S_READ;
      end

      S_READ: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        res_nxt.value_out  = '0;
        res_nxt.slot_index = '0;
        if (cmd_r == CMD_INSERT && rd_status_r != SLOT_USED) begin
          st_wr_en           = 1'b1;
          st_wr_data         = SLOT_USED;
          kv_wr_en           = 1'b1;
          res_nxt.status     = ST_OK;
          res_nxt.slot_index = SLOT_IDX_W'(pos_r);
          state_nxt          = S_DONE;
        end else if (cmd_r != CMD_INSERT && rd_status_r == SLOT_EMPTY) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else if (cmd_r != CMD_INSERT && key_hit) begin
          res_nxt.status     = ST_OK;
          res_nxt.value_out  = rd_value_r;
          res_nxt.slot_index = SLOT_IDX_W'(pos_r);
          if (cmd_r == CMD_DELETE) begin
            st_wr_en   = 1'b1;
            st_wr_data = SLOT_TOMB;
          end
          state_nxt = S_DONE;
        end else if (cnt_r == LAST_IDX) begin
          res_nxt.status = (cmd_r == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + IDX_W'(1);
          pos_nxt   = pos_wrap;
          state_nxt = S_READ;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Slot memories: one write port and one registered read port, both at the current slot.
  always_ff @(posedge clk) begin
    if (st_wr_en) begin
      status_mem[pos_r] <= st_wr_data;
    end
    if (kv_wr_en) begin
      key_mem[pos_r]   <= key_r;
      value_mem[pos_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_status_r <= status_mem[pos_r];
    rd_key_r    <= key_mem[pos_r];
    rd_value_r  <= value_mem[pos_r];
  end

  // A failed operation reports neither a value nor a slot.
  `HTLP_ASSERT(a_fail_fields_zero,
               out_valid_r && out_data_r.status != ST_OK |->
               out_data_r.value_out == '0 && out_data_r.slot_index == '0,
               "failed result carries a value or slot")

  // An accepted word either starts the home slot computation or answers at once.
  `HTLP_ASSERT(a_accept_next,
               in_accept |=> state_r == S_MOD || state_r == S_DONE,
               "accepted word did not start an operation")

  // Slot memories change only during the clearing pass or a probe decision.
  `HTLP_ASSERT_NEVER(a_write_state,
                     st_wr_en && state_r != S_CLEAR && state_r != S_EVAL,
                     "slot status written outside clear or probe")

  // Key and value are written only when a slot becomes used.
  `HTLP_ASSERT(a_kv_with_used,
               kv_wr_en |-> st_wr_en && st_wr_data == SLOT_USED && cmd_r == CMD_INSERT,
               "key/value written without marking the slot used")

endmodule
